// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, codes and types of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int SLOT_COUNT    = 8;
  localparam int TASK_ID_BITS  = 8;
  localparam int PERIOD_BITS   = 16;
  localparam int COUNTER_BITS  = 32;
  localparam int SLOT_BITS     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RMCNT_BITS    = $clog2(SLOT_COUNT + 1);

  // result field widths
  localparam int SLOT_IDX_BITS = 6;
  localparam int STATUS_BITS   = 7;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } pts_cmd_e;

  typedef enum logic [1:0] {
    KIND_ADD_ACK    = 2'd0,
    KIND_REMOVE_ACK = 2'd1,
    KIND_FIRE       = 2'd2,
    KIND_IDLE       = 2'd3
  } pts_kind_e;

  localparam logic [STATUS_BITS-1:0] ADD_ADDED   = STATUS_BITS'(0);
  localparam logic [STATUS_BITS-1:0] ADD_PRESENT = STATUS_BITS'(1);
  localparam logic [STATUS_BITS-1:0] ADD_FULL    = STATUS_BITS'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_REM_SCAN,
    ST_TICK_SCAN,
    ST_TICK_WAIT,
    ST_EMIT
  } pts_state_e;

  typedef struct packed {
    pts_kind_e                kind;
    logic [TASK_ID_BITS-1:0]  task_id;
    logic [SLOT_IDX_BITS-1:0] slot_index;
    logic [STATUS_BITS-1:0]   status;
    logic                     last;
  } pts_res_t;

endpackage

`default_nettype wire

// ===== src/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_in_if / pts_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_in_if;
  import pts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [PERIOD_BITS-1:0]  period;

  modport source (output valid, output command, output task_id, output period,
                  input ready);
  modport sink   (input valid, input command, input task_id, input period,
                  output ready);
endinterface

interface pts_out_if;
  import pts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [TASK_ID_BITS-1:0]  task_id_out;
  logic [SLOT_IDX_BITS-1:0] slot_index;
  logic [STATUS_BITS-1:0]   status;
  logic                     last;

  modport source (output valid, output kind, output task_id_out, output slot_index,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input task_id_out, input slot_index,
                  input status, input last, output ready);
endinterface

`default_nettype wire

// ===== src/pts_mod_unit.sv =====
// ----------------------------------------------------------------------------
// pts_mod_unit
// Iterative restoring remainder unit: counter value modulo period, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_mod_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pts_pkg::COUNTER_BITS-1:0] dividend_i,
  input  wire logic [pts_pkg::PERIOD_BITS-1:0]  divisor_i,
  output      logic                            busy_o,
  output      logic                            done_o,
  output      logic [pts_pkg::PERIOD_BITS-1:0]  rem_o
);
  import pts_pkg::*;

  localparam int CNT_BITS = $clog2(COUNTER_BITS + 1);

  logic [COUNTER_BITS-1:0] shift_q, shift_d;
  logic [PERIOD_BITS-1:0]  rem_q, rem_d;
  logic [PERIOD_BITS-1:0]  div_q, div_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [PERIOD_BITS:0]    trial;

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    trial   = {rem_q, shift_q[COUNTER_BITS-1]};
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
      cnt_d   = CNT_BITS'(COUNTER_BITS);
      busy_d  = 1'b1;
      done_d  = 1'b0;
    end else if (busy_q) begin
      // remainder stays below divisor, so the difference fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = PERIOD_BITS'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[PERIOD_BITS-1:0];
      end
      shift_d = {shift_q[COUNTER_BITS-2:0], 1'b0};
      cnt_d   = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== src/periodic_task_slot_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_top
// Slot table of periodic tasks with add, remove and tick commands.
// ----------------------------------------------------------------------------
// One command word at a time. Add and remove walk the slot table one slot a
// cycle and then hand off the result. A tick walks all slots; each valid slot
// runs a 32-step remainder in the shared modulo unit (start, 32 steps, then
// the remainder is taken), and an empty slot is simply passed over. Fired
// tasks come out in slot order, the last one flagged; a tick with nothing due
// gives a single idle word. The command side is ready only between commands;
// a finished result waits in the output register and does not hold up the
// walk until a second one is due.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module periodic_task_slot_scheduler_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pts_in_if.sink    cmd_i,
  pts_out_if.source res_o
);
  import pts_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

  pts_state_e state_q, state_d;

  logic                    slot_valid_q [SLOT_COUNT];
  logic [TASK_ID_BITS-1:0] slot_task_q  [SLOT_COUNT];
  logic [PERIOD_BITS-1:0]  slot_period_q[SLOT_COUNT];

  logic [SLOT_BITS-1:0]    ptr_q, ptr_d;
  logic [TASK_ID_BITS-1:0] id_q, id_d;
  logic [PERIOD_BITS-1:0]  per_q, per_d;
  logic [RMCNT_BITS-1:0]   rm_cnt_q, rm_cnt_d;
  logic [COUNTER_BITS-1:0] tick_cnt_q, tick_cnt_d;
  pts_res_t                pend_q, pend_d;
  logic                    pend_valid_q, pend_valid_d;
  pts_res_t                res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic                    wr_en, wr_valid;
  logic [TASK_ID_BITS-1:0] wr_task;
  logic [PERIOD_BITS-1:0]  wr_period;

  logic                    div_start, div_busy, div_done;
  logic [PERIOD_BITS-1:0]  div_rem, div_divisor;
  logic [COUNTER_BITS-1:0] div_dividend;

  logic                    out_free;
  logic                    cmd_acc;

  assign out_free  = !res_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc   = cmd_i.valid && cmd_i.ready;

  pts_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign div_dividend = tick_cnt_q + COUNTER_BITS'(ptr_q);
  // stored periods are never zero, kept safe all the same
  assign div_divisor  = (slot_period_q[ptr_q] == '0) ? PERIOD_BITS'(1)
                                                     : slot_period_q[ptr_q];

  always_comb begin
    pts_res_t                pend_n;
    logic                    fire;
    logic [RMCNT_BITS-1:0]   cnt_n;
    logic [SLOT_IDX_BITS-1:0] slot_ext;

    state_d      = state_q;
    ptr_d        = ptr_q;
    id_d         = id_q;
    per_d        = per_q;
    rm_cnt_d     = rm_cnt_q;
    tick_cnt_d   = tick_cnt_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    wr_en        = 1'b0;
    wr_valid     = 1'b0;
    wr_task      = '0;
    wr_period    = '0;
    div_start    = 1'b0;
    pend_n       = pend_q;
    fire         = 1'b0;
    cnt_n        = rm_cnt_q;
    slot_ext     = SLOT_IDX_BITS'(ptr_q);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          id_d     = cmd_i.task_id;
          per_d    = (cmd_i.period == '0) ? PERIOD_BITS'(1) : cmd_i.period;
          ptr_d    = '0;
          rm_cnt_d = '0;
          unique case (pts_cmd_e'(cmd_i.command))
            CMD_ADD:    state_d = ST_ADD_SCAN;
            CMD_REMOVE: state_d = ST_REM_SCAN;
            CMD_TICK: begin
              tick_cnt_d = tick_cnt_q + COUNTER_BITS'(1);
              state_d    = ST_TICK_SCAN;
            end
            default:    state_d = ST_IDLE;
          endcase
        end
      end

      ST_ADD_SCAN: begin
        pend_n.kind       = KIND_ADD_ACK;
        pend_n.task_id    = id_q;
        pend_n.slot_index = '0;
        pend_n.last       = 1'b1;
        pend_n.status     = ADD_FULL;
        priority if (!slot_valid_q[ptr_q]) begin
          wr_en             = 1'b1;
          wr_valid          = 1'b1;
          wr_task           = id_q;
          wr_period         = per_q;
          pend_n.slot_index = slot_ext;
          pend_n.status     = ADD_ADDED;
          pend_d            = pend_n;
          pend_valid_d      = 1'b1;
          state_d           = ST_EMIT;
        end else if (slot_task_q[ptr_q] == id_q) begin
          pend_n.status = ADD_PRESENT;
          pend_d        = pend_n;
          pend_valid_d  = 1'b1;
          state_d       = ST_EMIT;
        end else if (ptr_q == LAST_SLOT) begin
          pend_d       = pend_n;
          pend_valid_d = 1'b1;
          state_d      = ST_EMIT;
        end else begin
          ptr_d = ptr_q + SLOT_BITS'(1);
        end
      end

      ST_REM_SCAN: begin
        if (slot_valid_q[ptr_q] && slot_task_q[ptr_q] == id_q) begin
          wr_en = 1'b1;
          cnt_n = rm_cnt_q + RMCNT_BITS'(1);
        end
        rm_cnt_d = cnt_n;
        if (ptr_q == LAST_SLOT) begin
          pend_n.kind       = KIND_REMOVE_ACK;
          pend_n.task_id    = id_q;
          pend_n.slot_index = '0;
          pend_n.status     = STATUS_BITS'(cnt_n);
          pend_n.last       = 1'b1;
          pend_d            = pend_n;
          pend_valid_d      = 1'b1;
          state_d           = ST_EMIT;
        end else begin
          ptr_d = ptr_q + SLOT_BITS'(1);
        end
      end

      ST_TICK_SCAN: begin
        priority if (slot_valid_q[ptr_q]) begin
          div_start = 1'b1;
          state_d   = ST_TICK_WAIT;
        end else if (ptr_q == LAST_SLOT) begin
          if (!pend_valid_q) begin
            pend_n.kind       = KIND_IDLE;
            pend_n.task_id    = '0;
            pend_n.slot_index = '0;
            pend_n.status     = '0;
          end
          pend_n.last  = 1'b1;
          pend_d       = pend_n;
          pend_valid_d = 1'b1;
          state_d      = ST_EMIT;
        end else begin
          ptr_d = ptr_q + SLOT_BITS'(1);
        end
      end

      ST_TICK_WAIT: begin
        fire = (div_rem == '0);
        // a second fire needs the earlier word moved out first
        if (div_done && !(fire && pend_valid_q && !out_free)) begin
          if (fire) begin
            if (pend_valid_q) begin
              res_d       = pend_q;
              res_valid_d = 1'b1;
            end
            pend_n.kind       = KIND_FIRE;
            pend_n.task_id    = slot_task_q[ptr_q];
            pend_n.slot_index = slot_ext;
            pend_n.status     = '0;
            pend_n.last       = 1'b0;
          end
          if (ptr_q == LAST_SLOT) begin
            if (!(fire || pend_valid_q)) begin
              pend_n.kind       = KIND_IDLE;
              pend_n.task_id    = '0;
              pend_n.slot_index = '0;
              pend_n.status     = '0;
            end
            pend_n.last  = 1'b1;
            pend_d       = pend_n;
            pend_valid_d = 1'b1;
            state_d      = ST_EMIT;
          end else begin
            pend_d       = pend_n;
            pend_valid_d = fire || pend_valid_q;
            ptr_d        = ptr_q + SLOT_BITS'(1);
            state_d      = ST_TICK_SCAN;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          res_d        = pend_q;
          res_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ptr_q        <= '0;
      rm_cnt_q     <= '0;
      tick_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      rm_cnt_q     <= rm_cnt_d;
      tick_cnt_q   <= tick_cnt_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      if (wr_en) begin
        slot_valid_q[ptr_q] <= wr_valid;
      end
    end
  end

  // payload, qualified by the valid bits
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    per_q  <= per_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    if (wr_en) begin
      slot_task_q[ptr_q]   <= wr_task;
      slot_period_q[ptr_q] <= wr_period;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.task_id_out = res_q.task_id;
  assign res_o.slot_index  = res_q.slot_index;
  assign res_o.status      = res_q.status;
  assign res_o.last        = res_q.last;

  `ASSERT_NEVER(a_ready_with_pend, clk_i, rst_ni, cmd_i.ready && pend_valid_q)
  `ASSERT_NEVER(a_div_restart, clk_i, rst_ni, div_start && div_busy)
  `ASSERT_PROP(a_tick_cnt_hold, clk_i, rst_ni,
    !(cmd_acc && cmd_i.command == CMD_TICK) |=> $stable(tick_cnt_q))
  `ASSERT_PROP(a_emit_only_if_pend, clk_i, rst_ni,
    (state_q == ST_EMIT) |-> pend_valid_q)

endmodule

`default_nettype wire
